FILE: rtl/tsk_pkg.sv
// shared types and constants for the topological sort block
`timescale 1ns / 1ps

package tsk_pkg;

    localparam int NODE_W = 4;
    localparam int NCFG_W = 5;
    localparam int HW_NODE_LIM = 16;
    localparam logic [NCFG_W-1:0] NODE_COUNT_RST = 5'd16;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_BUILD,
        ST_SCAN,
        ST_POP,
        ST_FETCH,
        ST_RELAX,
        ST_FINISH,
        ST_CLEAR
    } tsk_state_t;

    typedef struct packed {
        logic load;
        logic build;
        logic scan;
        logic take;
        logic relax;
        logic finish;
        logic clear;
    } tsk_cmd_t;

    typedef struct packed {
        logic last_acc;
        logic cnt_end;
        logic q_empty;
        logic pend;
        logic out_free;
    } tsk_stat_t;

endpackage

FILE: rtl/tsk_in_if.sv
// matrix entry channel
`timescale 1ns / 1ps

interface tsk_in_if import tsk_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] row;
    logic [NODE_W-1:0] col;
    logic              edge_req;
    logic              last_entry;

    modport source (output valid, row, col, edge_req, last_entry, input ready);
    modport sink   (input valid, row, col, edge_req, last_entry, output ready);
endinterface

FILE: rtl/tsk_out_if.sv
// sorted node channel
`timescale 1ns / 1ps

interface tsk_out_if import tsk_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] node_number;
    logic              has_node;
    logic              last_node;
    logic              complete;

    modport source (output valid, node_number, has_node, last_node, complete, input ready);
    modport sink   (input valid, node_number, has_node, last_node, complete, output ready);
endinterface

FILE: rtl/tsk_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module tsk_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/tsk_ctrl.sv
// sequencer for load, in-degree build, scan and emission
`timescale 1ns / 1ps

module tsk_ctrl import tsk_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  tsk_stat_t stat,
    output tsk_cmd_t  cmd
);

    tsk_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (stat.last_acc)
                begin
                    state_next = ST_BUILD;
                end
            end
            ST_BUILD:
            begin
                if (stat.cnt_end)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.cnt_end)
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                state_next = stat.q_empty ? ST_FINISH : ST_FETCH;
            end
            ST_FETCH:
            begin
                if (!stat.pend || stat.out_free)
                begin
                    state_next = ST_RELAX;
                end
            end
            ST_RELAX:
            begin
                if (stat.cnt_end)
                begin
                    state_next = ST_POP;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_LOAD:   cmd.load   = 1'b1;
            ST_BUILD:  cmd.build  = 1'b1;
            ST_SCAN:   cmd.scan   = 1'b1;
            ST_POP:    cmd        = '0;
            ST_FETCH:  cmd.take   = !stat.pend || stat.out_free;
            ST_RELAX:  cmd.relax  = 1'b1;
            ST_FINISH: cmd.finish = stat.out_free;
            ST_CLEAR:  cmd.clear  = 1'b1;
            default:   cmd        = '0;
        endcase
    end

endmodule

FILE: rtl/tsk_dp.sv
// matrix, in-degree counters, ready queue and output register
`timescale 1ns / 1ps

module tsk_dp import tsk_pkg::*; #(
    parameter int MAX_NODES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    tsk_in_if.sink            in_ch,
    tsk_out_if.source         out_ch,
    input  logic              cfg_we,
    input  logic [NCFG_W-1:0] cfg_wdata,
    input  tsk_cmd_t          cmd,
    output tsk_stat_t         stat
);

    localparam int NODE_LIM = (MAX_NODES < HW_NODE_LIM) ? MAX_NODES : HW_NODE_LIM;
    localparam int IDX_W    = $clog2(NODE_LIM);
    localparam int CNT_W    = $clog2(NODE_LIM + 1);

    logic [NCFG_W-1:0]   node_count_reg;
    logic [NODE_LIM-1:0] adj_reg  [NODE_LIM];
    logic [NODE_LIM-1:0] adj_next [NODE_LIM];
    logic [CNT_W-1:0]    deg_reg  [NODE_LIM];
    logic [CNT_W-1:0]    deg_next [NODE_LIM];
    logic [IDX_W-1:0]    i_reg, i_next;
    logic [IDX_W-1:0]    u_reg;
    logic [CNT_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    tail_reg, tail_next;

    logic                out_valid_reg;
    logic [NODE_W-1:0]   out_node_reg;
    logic                out_has_reg;
    logic                out_last_reg;
    logic                out_comp_reg;

    logic [NCFG_W-1:0]   n_clamp;
    logic [CNT_W-1:0]    n_eff;
    logic                in_acc;
    logic                in_range;
    logic [IDX_W-1:0]    row_sel;
    logic [NODE_LIM-1:0] row_bits;
    logic [NODE_LIM-1:0] lane_on;
    logic                push;
    logic                out_free;
    logic                emit;
    logic [IDX_W-1:0]    q_rdata;

    // effective node count
    always_comb
    begin
        n_clamp = node_count_reg;
        if (node_count_reg == '0)
        begin
            n_clamp = NCFG_W'(1);
        end
        else if (node_count_reg > NCFG_W'(NODE_LIM))
        begin
            n_clamp = NCFG_W'(NODE_LIM);
        end
    end

    assign n_eff = CNT_W'(n_clamp);

    always_comb
    begin
        for (int j = 0; j < NODE_LIM; j++)
        begin
            lane_on[j] = CNT_W'(j) < n_eff;
        end
    end

    assign in_ch.ready = cmd.load;
    assign in_acc      = in_ch.valid && cmd.load;
    assign in_range    = (NCFG_W'(in_ch.row) < n_clamp) && (NCFG_W'(in_ch.col) < n_clamp);

    assign row_sel  = cmd.build ? i_reg : u_reg;
    assign row_bits = adj_reg[row_sel];

    assign push = (cmd.scan && (deg_reg[i_reg] == '0))
               || (cmd.relax && row_bits[i_reg] && (deg_reg[i_reg] == CNT_W'(1)));

    assign out_free = !out_valid_reg || out_ch.ready;
    assign emit     = (cmd.take && (head_reg != '0)) || cmd.finish;

    always_comb
    begin
        adj_next = adj_reg;
        if (cmd.clear)
        begin
            for (int k = 0; k < NODE_LIM; k++)
            begin
                adj_next[k] = '0;
            end
        end
        else if (in_acc && in_range)
        begin
            adj_next[in_ch.row[IDX_W-1:0]][in_ch.col[IDX_W-1:0]] = in_ch.edge_req;
        end
    end

    always_comb
    begin
        deg_next = deg_reg;
        if (in_acc && in_ch.last_entry)
        begin
            for (int k = 0; k < NODE_LIM; k++)
            begin
                deg_next[k] = '0;
            end
        end
        else if (cmd.build)
        begin
            for (int k = 0; k < NODE_LIM; k++)
            begin
                if (row_bits[k] && lane_on[k])
                begin
                    deg_next[k] = deg_reg[k] + CNT_W'(1);
                end
            end
        end
        else if (cmd.relax && row_bits[i_reg] && (deg_reg[i_reg] != '0))
        begin
            deg_next[i_reg] = deg_reg[i_reg] - CNT_W'(1);
        end
    end

    assign stat.cnt_end  = (i_reg == IDX_W'(n_eff - CNT_W'(1)));
    assign stat.last_acc = in_acc && in_ch.last_entry;
    assign stat.q_empty  = (head_reg == tail_reg);
    assign stat.pend     = (head_reg != '0);
    assign stat.out_free = out_free;

    always_comb
    begin
        i_next = i_reg;
        if (in_acc && in_ch.last_entry)
        begin
            i_next = '0;
        end
        else if (cmd.build || cmd.scan || cmd.relax)
        begin
            i_next = stat.cnt_end ? '0 : i_reg + IDX_W'(1);
        end

        head_next = head_reg;
        tail_next = tail_reg;
        if (cmd.clear)
        begin
            head_next = '0;
            tail_next = '0;
        end
        else
        begin
            if (cmd.take)
            begin
                head_next = head_reg + CNT_W'(1);
            end
            if (push)
            begin
                tail_next = tail_reg + CNT_W'(1);
            end
        end
    end

    // ready queue
    tsk_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NODE_LIM)
    ) u_queue (
        .clk   (clk),
        .we    (push),
        .waddr (tail_reg[IDX_W-1:0]),
        .wdata (i_reg),
        .raddr (head_reg[IDX_W-1:0]),
        .rdata (q_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
            for (int k = 0; k < NODE_LIM; k++)
            begin
                adj_reg[k] <= '0;
                deg_reg[k] <= '0;
            end
            i_reg         <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            adj_reg  <= adj_next;
            deg_reg  <= deg_next;
            i_reg    <= i_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // pending node and output word
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            u_reg <= q_rdata;
        end
        if (emit)
        begin
            if (cmd.finish && (head_reg == '0))
            begin
                out_node_reg <= '0;
                out_has_reg  <= 1'b0;
                out_last_reg <= 1'b1;
                out_comp_reg <= 1'b0;
            end
            else
            begin
                out_node_reg <= NODE_W'(u_reg);
                out_has_reg  <= 1'b1;
                out_last_reg <= cmd.finish;
                out_comp_reg <= cmd.finish && (head_reg == n_eff);
            end
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.node_number = out_node_reg;
    assign out_ch.has_node    = out_has_reg;
    assign out_ch.last_node   = out_last_reg;
    assign out_ch.complete    = out_comp_reg;

endmodule

FILE: rtl/topological_sort_kahn_top.sv
// top level of the kahn topological sort block
//
// channel    dir  word
// in_ch      in   row, col, edge_req, last_entry
// out_ch     out  node_number, has_node, last_node, complete
// cfg_we     in   cfg_wdata = node_count
//
// one matrix word per cycle while loading; a word with last_entry starts the sort
// sort time is set by the one-target-per-cycle relax walk over each emitted row
// results leave through one output register; a stalled output holds the walk
// reset clears matrix, counts and queue pointers at once; no clearing pass
`timescale 1ns / 1ps

module topological_sort_kahn_top import tsk_pkg::*; #(
    parameter int MAX_NODES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    tsk_in_if.sink            in_ch,
    tsk_out_if.source         out_ch,
    input  logic              cfg_we,
    input  logic [NCFG_W-1:0] cfg_wdata
);

    tsk_cmd_t  cmd;
    tsk_stat_t stat;

    tsk_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    tsk_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
